// ===== rtl/core/pcce_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pcce_pkg;

  localparam int MAX_KNOTS = 64;
  localparam int IDX_W     = $clog2(MAX_KNOTS);
  localparam int CNT_W     = 7;
  localparam int TIME_W    = 32;
  localparam int VAL_W     = 48;
  localparam int WIDE_W    = 52;
  localparam int LO_W      = 32;
  localparam int HI_W      = WIDE_W - LO_W;
  localparam int PROD_W    = WIDE_W + TIME_W;
  localparam int FRAC_SH   = 24;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_KNOTS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_RATE = 1'b1;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic                    mode;
    logic [5:0]              entry_index;
    logic [TIME_W-1:0]       knot_time;
    logic signed [VAL_W-1:0] coef_a;
    logic signed [VAL_W-1:0] coef_b;
    logic signed [VAL_W-1:0] coef_c;
    logic signed [VAL_W-1:0] coef_d;
    logic [TIME_W-1:0]       query_time;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] rate;
    logic signed [VAL_W-1:0] slope;
    logic signed [VAL_W-1:0] curvature;
    logic                    below_range;
    logic                    saturated;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHK0, ST_SCAN, ST_FETCH, ST_OPND,
    ST_MLO, ST_MHI, ST_RND, ST_ADD, ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    OP_H1, OP_H2, OP_RATE, OP_S1, OP_SLOPE, OP_CURV
  } op_t;

endpackage
`default_nettype wire

// ===== rtl/core/piecewise_cubic_curve_eval.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A query whose time precedes the first knot goes from ST_CHK0 straight to ST_OUT;
// otherwise, with n being num_knots clamped to 2..64, the segment scan (skipped when n
// is 2) makes one knot memory read per cycle, then six products run on one shared 32x32
// multiplier, each via ST_OPND, ST_MLO, ST_MHI, ST_RND, ST_ADD. Loads write the memories.
// One item at a time; input stalls until the result is taken.
// Synchronous active-low reset: returns to idle, num_knots = 2, first_rate = 0;
// the knot and coefficient memories are not cleared.
module piecewise_cubic_curve_eval (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  wire                                     in_valid,
  output logic                                    in_stall,
  input  pcce_pkg::in_item_t                      in_data,
  output logic                                    out_valid,
  input  wire                                     out_stall,
  output pcce_pkg::out_item_t                     out_data,
  input  wire                                     cfg_we,
  input  wire [pcce_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  wire [pcce_pkg::VAL_W-1:0]               cfg_wdata
);

  localparam logic signed [pcce_pkg::WIDE_W-1:0] POS_LIM =
    pcce_pkg::WIDE_W'((64'sd1 <<< (pcce_pkg::VAL_W - 1)) - 64'sd1);
  localparam logic signed [pcce_pkg::WIDE_W-1:0] NEG_LIM =
    pcce_pkg::WIDE_W'(-(64'sd1 <<< (pcce_pkg::VAL_W - 1)));

  pcce_pkg::state_t state_r, state_nxt;
  pcce_pkg::op_t    op_r, op_nxt;

  logic [pcce_pkg::CNT_W-1:0]         num_knots_r, n_r, n_nxt, i_r, i_nxt;
  logic signed [pcce_pkg::VAL_W-1:0]  first_rate_r;
  logic [pcce_pkg::TIME_W-1:0]        t_r, t_nxt, base_r, base_nxt, dt_r, dt_nxt;
  logic                               cmp_v_r, cmp_v_nxt, neg_r, neg_nxt, sat_r, sat_nxt;
  logic [pcce_pkg::IDX_W-1:0]         cmp_i_r, cmp_i_nxt, k_r, k_nxt, knot_addr;
  logic [pcce_pkg::WIDE_W-1:0]        m_r, m_nxt;
  logic [2*pcce_pkg::LO_W-1:0]        lo_r, lo_nxt;
  logic [pcce_pkg::WIDE_W-1:0]        mid_r, mid_nxt;
  logic signed [pcce_pkg::VAL_W-1:0]  mres_r, mres_nxt;
  logic signed [pcce_pkg::WIDE_W-1:0] h_r, h_nxt;
  pcce_pkg::out_item_t                out_r, out_nxt;

  logic [pcce_pkg::TIME_W-1:0]        knot_mem [pcce_pkg::MAX_KNOTS];
  logic signed [pcce_pkg::VAL_W-1:0]  a_mem [pcce_pkg::MAX_KNOTS];
  logic signed [pcce_pkg::VAL_W-1:0]  b_mem [pcce_pkg::MAX_KNOTS];
  logic signed [pcce_pkg::VAL_W-1:0]  c_mem [pcce_pkg::MAX_KNOTS];
  logic signed [pcce_pkg::VAL_W-1:0]  d_mem [pcce_pkg::MAX_KNOTS];
  logic [pcce_pkg::TIME_W-1:0]        knot_q;
  logic signed [pcce_pkg::VAL_W-1:0]  a_q, b_q, c_q, d_q;

  logic in_acc, load_acc, query_acc;
  logic [pcce_pkg::CNT_W-1:0]         n_last, n_clamp;
  logic signed [pcce_pkg::WIDE_W-1:0] a_w, b_w, c_w, d_w, x_sel, add_sel, sum;
  logic [pcce_pkg::LO_W-1:0]          mul_a;
  logic [2*pcce_pkg::LO_W-1:0]        mul_p;
  logic [pcce_pkg::PROD_W-1:0]        prod;
  logic [pcce_pkg::PROD_W-pcce_pkg::FRAC_SH-1:0] q_full, q_lim;
  logic [pcce_pkg::VAL_W-1:0]         q48;
  logic                               q_over, sum_hi, sum_lo, last_op, final_op;
  logic signed [pcce_pkg::VAL_W-1:0]  sum_clip;

  assign in_acc    = in_valid && !in_stall;
  assign load_acc  = in_acc && (in_data.mode == pcce_pkg::MODE_LOAD);
  assign query_acc = in_acc && (in_data.mode == pcce_pkg::MODE_QUERY);
  assign out_data  = out_r;
  assign n_last    = n_r - pcce_pkg::CNT_W'(1);

  always_ff @(posedge clk) begin
    if (load_acc) begin
      knot_mem[in_data.entry_index] <= in_data.knot_time;
      a_mem[in_data.entry_index]    <= in_data.coef_a;
      b_mem[in_data.entry_index]    <= in_data.coef_b;
      c_mem[in_data.entry_index]    <= in_data.coef_c;
      d_mem[in_data.entry_index]    <= in_data.coef_d;
    end
    knot_q <= knot_mem[knot_addr];
    a_q    <= a_mem[k_r];
    b_q    <= b_mem[k_r];
    c_q    <= c_mem[k_r];
    d_q    <= d_mem[k_r];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pcce_pkg::ST_IDLE:  if (query_acc) state_nxt = pcce_pkg::ST_CHK0;
      pcce_pkg::ST_CHK0: begin
        if (t_r < knot_q) state_nxt = pcce_pkg::ST_OUT;
        else if (n_r == pcce_pkg::CNT_W'(2)) state_nxt = pcce_pkg::ST_FETCH;
        else state_nxt = pcce_pkg::ST_SCAN;
      end
      pcce_pkg::ST_SCAN:  if (i_r == n_last) state_nxt = pcce_pkg::ST_FETCH;
      pcce_pkg::ST_FETCH: state_nxt = pcce_pkg::ST_OPND;
      pcce_pkg::ST_OPND:  state_nxt = pcce_pkg::ST_MLO;
      pcce_pkg::ST_MLO:   state_nxt = pcce_pkg::ST_MHI;
      pcce_pkg::ST_MHI:   state_nxt = pcce_pkg::ST_RND;
      pcce_pkg::ST_RND:   state_nxt = pcce_pkg::ST_ADD;
      pcce_pkg::ST_ADD:   state_nxt = last_op ? pcce_pkg::ST_OUT : pcce_pkg::ST_OPND;
      pcce_pkg::ST_OUT:   if (!out_stall) state_nxt = pcce_pkg::ST_IDLE;
      default:            state_nxt = pcce_pkg::ST_IDLE;
    endcase
  end

  // handshake and memory address
  always_comb begin
    in_stall  = (state_r != pcce_pkg::ST_IDLE);
    out_valid = (state_r == pcce_pkg::ST_OUT);
    knot_addr = (state_r == pcce_pkg::ST_SCAN) ? i_r[pcce_pkg::IDX_W-1:0]
                                               : '0;
  end

  // shared multiply datapath
  always_comb begin
    a_w = pcce_pkg::WIDE_W'(a_q);
    b_w = pcce_pkg::WIDE_W'(b_q);
    c_w = pcce_pkg::WIDE_W'(c_q);
    d_w = pcce_pkg::WIDE_W'(d_q);
    last_op  = (op_r == pcce_pkg::OP_CURV);
    final_op = (op_r == pcce_pkg::OP_RATE) || (op_r == pcce_pkg::OP_SLOPE) ||
               (op_r == pcce_pkg::OP_CURV);
    case (op_r)
      pcce_pkg::OP_H1:    x_sel = d_w;
      pcce_pkg::OP_S1:    x_sel = (d_w <<< 1) + d_w;
      pcce_pkg::OP_CURV:  x_sel = (d_w <<< 2) + (d_w <<< 1);
      default:            x_sel = h_r;
    endcase
    case (op_r)
      pcce_pkg::OP_H1:    add_sel = c_w;
      pcce_pkg::OP_RATE:  add_sel = a_w;
      pcce_pkg::OP_S1,
      pcce_pkg::OP_CURV:  add_sel = c_w <<< 1;
      default:            add_sel = b_w;
    endcase
    // low half of the magnitude first, then the high half
    mul_a  = (state_r == pcce_pkg::ST_MLO) ? m_r[pcce_pkg::LO_W-1:0]
                                           : pcce_pkg::LO_W'(m_r[pcce_pkg::WIDE_W-1:pcce_pkg::LO_W]);
    mul_p  = (2*pcce_pkg::LO_W)'(mul_a) * (2*pcce_pkg::LO_W)'(dt_r);
    prod   = pcce_pkg::PROD_W'(lo_r) + (pcce_pkg::PROD_W'(mid_r) << pcce_pkg::LO_W)
           + (pcce_pkg::PROD_W'(1) << (pcce_pkg::FRAC_SH - 1));
    q_full = prod[pcce_pkg::PROD_W-1:pcce_pkg::FRAC_SH];
    q_lim  = neg_r ? (pcce_pkg::PROD_W-pcce_pkg::FRAC_SH)'(1) << (pcce_pkg::VAL_W - 1)
                   : ((pcce_pkg::PROD_W-pcce_pkg::FRAC_SH)'(1) << (pcce_pkg::VAL_W - 1))
                     - (pcce_pkg::PROD_W-pcce_pkg::FRAC_SH)'(1);
    q_over = q_full > q_lim;
    q48    = q_over ? q_lim[pcce_pkg::VAL_W-1:0] : q_full[pcce_pkg::VAL_W-1:0];
    sum    = add_sel + pcce_pkg::WIDE_W'(mres_r);
    sum_hi = sum > POS_LIM;
    sum_lo = sum < NEG_LIM;
    sum_clip = sum_hi ? POS_LIM[pcce_pkg::VAL_W-1:0]
             : sum_lo ? NEG_LIM[pcce_pkg::VAL_W-1:0] : sum[pcce_pkg::VAL_W-1:0];
  end

  // register updates
  always_comb begin
    n_clamp = (in_data.mode == pcce_pkg::MODE_QUERY && num_knots_r < pcce_pkg::CNT_W'(2))
              ? pcce_pkg::CNT_W'(2)
              : (num_knots_r > pcce_pkg::CNT_W'(pcce_pkg::MAX_KNOTS))
                ? pcce_pkg::CNT_W'(pcce_pkg::MAX_KNOTS) : num_knots_r;
    n_nxt = n_r;   t_nxt = t_r;   i_nxt = i_r;   cmp_v_nxt = cmp_v_r;
    cmp_i_nxt = cmp_i_r;   k_nxt = k_r;   base_nxt = base_r;   dt_nxt = dt_r;
    op_nxt = op_r;   neg_nxt = neg_r;   m_nxt = m_r;   lo_nxt = lo_r;
    mid_nxt = mid_r;   mres_nxt = mres_r;   h_nxt = h_r;   sat_nxt = sat_r;
    out_nxt = out_r;
    case (state_r)
      pcce_pkg::ST_IDLE: begin
        n_nxt   = n_clamp;
        t_nxt   = in_data.query_time;
        sat_nxt = 1'b0;
      end
      pcce_pkg::ST_CHK0: begin
        base_nxt  = knot_q;
        k_nxt     = '0;
        i_nxt     = pcce_pkg::CNT_W'(1);
        cmp_v_nxt = 1'b0;
        op_nxt    = pcce_pkg::OP_H1;
        out_nxt   = '{rate: first_rate_r, slope: '0, curvature: '0,
                      below_range: 1'b1, saturated: 1'b0};
      end
      pcce_pkg::ST_SCAN: begin
        // compare the knot read last cycle, issue the next read
        if (cmp_v_r && knot_q <= t_r) begin
          k_nxt    = cmp_i_r;
          base_nxt = knot_q;
        end
        cmp_v_nxt = (i_r != n_last);
        cmp_i_nxt = i_r[pcce_pkg::IDX_W-1:0];
        if (i_r != n_last) i_nxt = i_r + pcce_pkg::CNT_W'(1);
      end
      pcce_pkg::ST_FETCH: dt_nxt = t_r - base_r;
      pcce_pkg::ST_OPND: begin
        neg_nxt = x_sel[pcce_pkg::WIDE_W-1];
        m_nxt   = neg_nxt ? pcce_pkg::WIDE_W'(-x_sel) : pcce_pkg::WIDE_W'(x_sel);
      end
      pcce_pkg::ST_MLO:
        lo_nxt = mul_p;
      pcce_pkg::ST_MHI:
        mid_nxt = mul_p[pcce_pkg::WIDE_W-1:0];
      pcce_pkg::ST_RND: begin
        mres_nxt = neg_r ? -q48 : q48;
        if (q_over) sat_nxt = 1'b1;
      end
      pcce_pkg::ST_ADD: begin
        h_nxt = sum;
        if (final_op && (sum_hi || sum_lo)) sat_nxt = 1'b1;
        case (op_r)
          pcce_pkg::OP_RATE:  out_nxt.rate      = sum_clip;
          pcce_pkg::OP_SLOPE: out_nxt.slope     = sum_clip;
          pcce_pkg::OP_CURV:  out_nxt.curvature = sum_clip;
          default:            out_nxt.rate      = out_r.rate;
        endcase
        out_nxt.below_range = 1'b0;
        out_nxt.saturated   = sat_nxt;
        op_nxt = last_op ? op_r : pcce_pkg::op_t'(op_r + 3'd1);
      end
      default: out_nxt = out_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pcce_pkg::ST_IDLE;
      num_knots_r  <= pcce_pkg::CNT_W'(2);
      first_rate_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we && cfg_index == pcce_pkg::CFG_NUM_KNOTS)
        num_knots_r <= cfg_wdata[pcce_pkg::CNT_W-1:0];
      if (cfg_we && cfg_index == pcce_pkg::CFG_FIRST_RATE)
        first_rate_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    n_r <= n_nxt;   t_r <= t_nxt;   i_r <= i_nxt;   cmp_v_r <= cmp_v_nxt;
    cmp_i_r <= cmp_i_nxt;   k_r <= k_nxt;   base_r <= base_nxt;   dt_r <= dt_nxt;
    op_r <= op_nxt;   neg_r <= neg_nxt;   m_r <= m_nxt;   lo_r <= lo_nxt;
    mid_r <= mid_nxt;   mres_r <= mres_nxt;   h_r <= h_nxt;   sat_r <= sat_nxt;
    out_r <= out_nxt;
  end

endmodule
`default_nettype wire
